// ----- design/tawd_pkg.sv -----
// Shared types, constants and helpers for the tilt angle window detector.
package tawd_pkg;

   localparam int WindowLen = 15;
   localparam int PosW = $clog2(WindowLen);
   localparam int CntW = $clog2(WindowLen + 1);

   localparam logic signed [34:0] QOne = 35'sd65536;
   localparam logic signed [34:0] QK028 = 35'sd18350;
   localparam logic signed [34:0] QHalfPi = 35'sd102944;
   localparam logic signed [34:0] QPi = 35'sd205887;

   // ceil(18000 * 2^36 / QPi); exact truncating divide for |rad| < 2^18
   localparam logic [32:0] CdRecip = 33'd6007910074;

   localparam logic [1:0] CSR_RANGE = 2'd0;
   localparam logic [1:0] CSR_THRESH = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // sample pair as queued between front and back
   typedef struct packed {
      logic signed [16:0] x_mg;
      logic signed [16:0] z_mg;
   } pair_type;

   typedef struct packed {
      logic signed [15:0] tilt_centideg;
      logic is_above;
      logic [3:0] window_count;
      logic detected;
   } result_type;

   function automatic logic [14:0] full_scale(input logic [1:0] sel);
      unique case (sel)
         2'd0: full_scale = 15'd2000;
         2'd1: full_scale = 15'd4000;
         2'd2: full_scale = 15'd8000;
         default: full_scale = 15'd16000;
      endcase
   endfunction

endpackage

// ----- design/tawd_divider.sv -----
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
module tawd_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic busy,
   output logic done,
   output logic signed [63:0] quo
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] shifted;

   always_comb begin
      rem_in = rem_ff;
      q_in = q_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[62:0], q_ff[63]};
      trial = {1'b0, shifted} - {1'b0, d_ff};
      if (start) begin
         rem_in = '0;
         q_in = num[63] ? 64'(-num) : num;
         d_in = den[63] ? 64'(-den) : den;
         neg_in = num[63] ^ den[63];
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff <= q_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo = neg_ff ? 64'(-q_ff) : q_ff;
endmodule

// ----- design/tawd_front.sv -----
// Front end: takes requests, scales samples to milli-g, fills the queue.
module tawd_front (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0] range_sel,
   output logic q_valid,
   input  logic q_pop,
   output tawd_pkg::pair_type q_data
);
   // two-entry queue
   tawd_pkg::pair_type mem_ff [2];
   logic [1:0] cnt_ff;
   logic wp_ff, rp_ff;
   logic push;
   logic signed [26:0] xp, zp;
   logic signed [15:0] fs;
   tawd_pkg::pair_type item;

   assign fs = signed'({1'b0, tawd_pkg::full_scale(range_sel)});
   assign xp = signed'(req_tdata[11:0]) * fs;
   assign zp = signed'(req_tdata[23:12]) * fs;
   // divide by 1024 toward zero
   assign item.x_mg = 17'((xp + (xp[26] ? 27'sd1023 : 27'sd0)) >>> 10);
   assign item.z_mg = 17'((zp + (zp[26] ? 27'sd1023 : 27'sd0)) >>> 10);

   assign req_tready = cnt_ff != 2'd2;
   assign push = req_tvalid && req_tready;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= item;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (q_pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop of empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !q_pop) |=> cnt_ff == 2'd2)
      else $error("queue lost entry");
endmodule

// ----- design/tawd_back.sv -----
// Back end: atan2 sequencer on a shared divider, window ring and result register.
module tawd_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_pop,
   input  tawd_pkg::pair_type q_data,
   input  logic signed [15:0] thresh,
   input  logic [3:0] limit,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output tawd_pkg::result_type rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_DIVQ, S_WQ, S_SQ, S_MK, S_DEN, S_DIVA, S_WA, S_FIX, S_CD, S_MULC, S_WC,
      S_WIN, S_OUT
   } state_type;

   state_type st_ff;
   logic signed [16:0] x_ff, z_ff;
   logic signed [34:0] q_ff;
   logic signed [47:0] q2_ff;
   logic signed [47:0] den_ff;
   logic signed [36:0] a_ff;
   logic signed [47:0] prod_ff;
   logic [17:0] mag_ff;
   logic cd_neg_ff;
   logic [50:0] cprod_ff;
   logic signed [15:0] cd_ff;
   logic [tawd_pkg::WindowLen-1:0] ring_ff;
   logic [tawd_pkg::PosW-1:0] pos_ff;
   logic [tawd_pkg::CntW-1:0] cnt_ff;
   tawd_pkg::result_type rsp_ff;
   logic rv_ff;

   logic start;
   logic signed [63:0] num, den;
   logic busy, done;
   logic signed [63:0] quo;
   logic shallow;
   logic above;
   logic [tawd_pkg::CntW-1:0] newcnt;

   tawd_divider u_div (.clock, .reset, .start, .num, .den, .busy, .done, .quo);

   assign shallow = q_ff > -tawd_pkg::QOne && q_ff < tawd_pkg::QOne;
   assign above = cd_ff > thresh;
   assign newcnt = cnt_ff + tawd_pkg::CntW'(above) - tawd_pkg::CntW'(ring_ff[pos_ff]);

   always_comb begin
      start = 1'b0;
      num = '0;
      den = 64'sd1;
      unique case (st_ff)
         S_DIVQ: begin
            start = 1'b1;
            num = 64'(z_ff) <<< 16;
            den = 64'(x_ff);
         end
         S_DIVA: begin
            start = 1'b1;
            num = 64'(q_ff) <<< 16;
            den = 64'(den_ff);
         end
         default: ;
      endcase
   end

   assign q_pop = st_ff == S_IDLE && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ring_ff <= '0;
         pos_ff <= '0;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready && st_ff != S_WIN) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (q_valid) begin
               x_ff <= q_data.x_mg;
               z_ff <= q_data.z_mg;
               if (q_data.x_mg == 17'sd0) begin
                  a_ff <= (q_data.z_mg == 17'sd0) ? 37'sd0 :
                          (q_data.z_mg > 17'sd0) ? 37'(tawd_pkg::QHalfPi)
                                                 : -37'(tawd_pkg::QHalfPi);
                  st_ff <= S_CD;
               end else st_ff <= S_DIVQ;
            end
            S_DIVQ: st_ff <= S_WQ;
            S_WQ: if (done) begin
               if (quo > 64'sd2147483647) q_ff <= 35'sd2147483647;
               else if (quo < -64'sd2147483648) q_ff <= -35'sd2147483648;
               else q_ff <= 35'(quo);
               st_ff <= S_SQ;
            end
            S_SQ: begin
               // q*q >> 16; product is nonnegative so shift equals truncation
               q2_ff <= 48'((64'(q_ff) * 64'(q_ff)) >>> 16);
               st_ff <= S_MK;
            end
            S_MK: begin
               // only used on the shallow side, where q2 is below 2^16
               prod_ff <= 48'(q2_ff[16:0]) * 48'(tawd_pkg::QK028);
               st_ff <= S_DEN;
            end
            S_DEN: begin
               den_ff <= shallow ? 48'(tawd_pkg::QOne) + (prod_ff >>> 16)
                                 : q2_ff + 48'(tawd_pkg::QK028);
               st_ff <= S_DIVA;
            end
            S_DIVA: st_ff <= S_WA;
            S_WA: if (done) begin
               a_ff <= 37'(quo);
               st_ff <= S_FIX;
            end
            S_FIX: begin
               if (shallow) begin
                  if (x_ff < 0)
                     a_ff <= (z_ff < 0) ? a_ff - 37'(tawd_pkg::QPi)
                                        : a_ff + 37'(tawd_pkg::QPi);
               end else begin
                  a_ff <= 37'(tawd_pkg::QHalfPi) - a_ff -
                          ((z_ff < 0) ? 37'(tawd_pkg::QPi) : 37'sd0);
               end
               st_ff <= S_CD;
            end
            S_CD: begin
               // |rad| never exceeds pi, so 18 bits of magnitude suffice
               mag_ff <= (a_ff < 0) ? 18'(-a_ff) : 18'(a_ff);
               cd_neg_ff <= a_ff < 0;
               st_ff <= S_MULC;
            end
            S_MULC: begin
               cprod_ff <= mag_ff * tawd_pkg::CdRecip;
               st_ff <= S_WC;
            end
            S_WC: begin
               cd_ff <= cd_neg_ff ? -16'(cprod_ff[50:36]) : 16'(cprod_ff[50:36]);
               st_ff <= S_WIN;
            end
            S_WIN: if (!rv_ff || rsp_tready) begin
               rsp_ff.tilt_centideg <= cd_ff;
               rsp_ff.is_above <= above;
               rsp_ff.window_count <= 4'(newcnt);
               rv_ff <= 1'b1;
               if (newcnt >= tawd_pkg::CntW'(limit)) begin
                  rsp_ff.detected <= 1'b1;
                  ring_ff <= '0;
                  pos_ff <= '0;
                  cnt_ff <= '0;
               end else begin
                  rsp_ff.detected <= 1'b0;
                  ring_ff[pos_ff] <= above;
                  pos_ff <= (pos_ff == tawd_pkg::PosW'(tawd_pkg::WindowLen - 1)) ? '0
                                                                          : pos_ff + 1'b1;
                  cnt_ff <= newcnt;
               end
               st_ff <= S_OUT;
            end
            S_OUT: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == tawd_pkg::CntW'($countones(ring_ff)))
      else $error("window count out of step with ring");
   assert property (@(posedge clock) disable iff (reset)
      pos_ff < tawd_pkg::PosW'(tawd_pkg::WindowLen))
      else $error("ring position out of range");
   assert property (@(posedge clock) disable iff (reset) start |-> !busy)
      else $error("divider restarted while busy");
endmodule

// ----- design/tilt_angle_window_detector_core.sv -----
// Top level of the tilt angle window detector.
// Usage:
//   req channel: tdata[11:0] = x_sample, tdata[23:12] = z_sample (signed raw counts).
//   rsp channel: one result per request, see port comment for packing.
//   csr port: index 0 range_select, 1 angle_threshold, 2 count_limit; write when idle.
// Front scales samples to milli-g (one multiply each) and queues up to two pairs.
// Back computes atan2 with two passes through one bit-serial 64-bit divider,
// then turns radians into centidegrees by a reciprocal multiply.
// X of zero skips both passes. The divider sets the rate; one item is worked at a time.
// Detection fires when the window count reaches count_limit; the 15-flag ring
// then clears.
// Reset: registers return to 1 / 3000 / 10, ring, position and count clear.
// A stalled rsp holds its result; the back waits, the queue fills, then req_tready
// drops.
module tilt_angle_window_detector_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata, // x_sample[11:0], z_sample[23:12]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata, // tilt[15:0], is_above[16], count[20:17], det[21], 0
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   logic [1:0] range_ff;
   logic signed [15:0] thresh_ff;
   logic [3:0] limit_ff;
   logic q_valid, q_pop;
   tawd_pkg::pair_type q_data;
   tawd_pkg::result_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 2'd1;
         thresh_ff <= 16'sd3000;
         limit_ff <= 4'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            tawd_pkg::CSR_RANGE: range_ff <= csr_wdata[1:0];
            tawd_pkg::CSR_THRESH: thresh_ff <= csr_wdata;
            tawd_pkg::CSR_LIMIT: limit_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   tawd_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .range_sel(range_ff), .q_valid, .q_pop, .q_data);

   tawd_back u_back (.clock, .reset, .q_valid, .q_pop, .q_data, .thresh(thresh_ff),
      .limit(limit_ff), .rsp_tvalid, .rsp_tready, .rsp);

   assign rsp_tdata = {2'b00, rsp.detected, rsp.window_count, rsp.is_above,
      rsp.tilt_centideg};

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tdata[20:17] >= limit_ff)
      else $error("detection below limit");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop without entry");
endmodule
